// ===== design/cotb_pkg.sv =====
`default_nettype none

package cotb_pkg;

	localparam int NUM_TIMERS  = 3;
	localparam int COUNT_WIDTH = 16;
	localparam int IRQ_LINES   = 3;

	// Item actions
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// Register selects
	localparam logic [1:0] REG_COUNT   = 2'd0;
	localparam logic [1:0] REG_MODE    = 2'd1;
	localparam logic [1:0] REG_COMPARE = 2'd2;

	// Clock sources
	localparam logic [1:0] CLK_BUS    = 2'd0;
	localparam logic [1:0] CLK_DIV16  = 2'd1;
	localparam logic [1:0] CLK_DIV256 = 2'd2;
	localparam logic [1:0] CLK_HBLANK = 2'd3;

	// Mode register bit positions
	localparam int MODE_CLK_LO   = 0;
	localparam int MODE_CLK_HI   = 1;
	localparam int MODE_ZERO     = 6;
	localparam int MODE_ENABLE   = 7;
	localparam int MODE_CMP_IRQ  = 8;
	localparam int MODE_OVF_IRQ  = 9;
	localparam int MODE_CMP_FLAG = 10;
	localparam int MODE_OVF_FLAG = 11;

	typedef logic [COUNT_WIDTH-1:0] cnt_t;

	typedef struct packed {
		logic [1:0]  action;
		logic        hblank_pulse;
		logic [1:0]  timer_index;
		logic [1:0]  reg_select;
		logic [15:0] write_data;
	} item_t;

	typedef struct packed {
		logic [15:0]          read_data;
		logic [IRQ_LINES-1:0] irq_lines;
	} result_t;

	typedef struct packed {
		logic en;
		logic p16;
		logic p256;
		logic hblank;
	} tick_t;

	typedef struct packed {
		logic        en;
		logic [1:0]  reg_select;
		logic [15:0] data;
	} wr_t;

	typedef struct packed {
		cnt_t        count;
		cnt_t        compare;
		logic [15:0] mode;
		logic        irq_next;
	} view_t;

endpackage

`default_nettype wire

// ===== design/cotb_timer.sv =====
`default_nettype none

module cotb_timer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  cotb_pkg::tick_t  tick,
	input  cotb_pkg::wr_t    wr,
	output cotb_pkg::view_t  view
);
	import cotb_pkg::*;

	cnt_t       count_q, compare_q;
	logic [1:0] src_q;
	logic       zero_q, enable_q, cmp_ie_q, ovf_ie_q, cmp_f_q, ovf_f_q;

	cnt_t       count_d, compare_d, inc;
	logic [1:0] src_d;
	logic       zero_d, enable_d, cmp_ie_d, ovf_ie_d, cmp_f_d, ovf_f_d;
	logic       pulse, advance;

	always_comb begin
		case (src_q)
			CLK_BUS:    pulse = 1'b1;
			CLK_DIV16:  pulse = tick.p16;
			CLK_DIV256: pulse = tick.p256;
			default:    pulse = tick.hblank;
		endcase
		advance = tick.en && enable_q && pulse;
		inc     = count_q + cnt_t'(1);

		count_d   = count_q;
		compare_d = compare_q;
		src_d     = src_q;
		zero_d    = zero_q;
		enable_d  = enable_q;
		cmp_ie_d  = cmp_ie_q;
		ovf_ie_d  = ovf_ie_q;
		cmp_f_d   = cmp_f_q;
		ovf_f_d   = ovf_f_q;

		if (advance) begin
			count_d = inc;
			if (&count_q) begin
				ovf_f_d = 1'b1;
			end
			// Compare is checked against the incremented value, so a wrap onto
			// a compare of zero raises both flags.
			if (inc == compare_q) begin
				cmp_f_d = 1'b1;
				if (zero_q) begin
					count_d = '0;
				end
			end
		end

		if (wr.en) begin
			unique case (wr.reg_select)
				REG_COUNT: begin
					count_d = cnt_t'(wr.data);
				end
				REG_MODE: begin
					src_d    = wr.data[MODE_CLK_HI:MODE_CLK_LO];
					zero_d   = wr.data[MODE_ZERO];
					enable_d = wr.data[MODE_ENABLE];
					cmp_ie_d = wr.data[MODE_CMP_IRQ];
					ovf_ie_d = wr.data[MODE_OVF_IRQ];
					if (wr.data[MODE_CMP_FLAG]) begin
						cmp_f_d = 1'b0;
					end
					if (wr.data[MODE_OVF_FLAG]) begin
						ovf_f_d = 1'b0;
					end
				end
				REG_COMPARE: begin
					compare_d = cnt_t'(wr.data);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			compare_q <= '0;
			src_q     <= CLK_BUS;
			zero_q    <= 1'b0;
			enable_q  <= 1'b0;
			cmp_ie_q  <= 1'b0;
			ovf_ie_q  <= 1'b0;
			cmp_f_q   <= 1'b0;
			ovf_f_q   <= 1'b0;
		end else if (step) begin
			count_q   <= count_d;
			compare_q <= compare_d;
			src_q     <= src_d;
			zero_q    <= zero_d;
			enable_q  <= enable_d;
			cmp_ie_q  <= cmp_ie_d;
			ovf_ie_q  <= ovf_ie_d;
			cmp_f_q   <= cmp_f_d;
			ovf_f_q   <= ovf_f_d;
		end
	end

	assign view.count    = count_q;
	assign view.compare  = compare_q;
	assign view.mode     = {4'b0000, ovf_f_q, cmp_f_q, ovf_ie_q, cmp_ie_q,
	                        enable_q, zero_q, 4'b0000, src_q};
	// The result reports the interrupt level after this transfer's update.
	assign view.irq_next = (cmp_f_d && cmp_ie_d) || (ovf_f_d && ovf_ie_d);

endmodule

`default_nettype wire

// ===== design/compare_overflow_timer_bank.sv =====
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_ready    cotb_pkg::item_t
// result    out        result_valid / result_ready cotb_pkg::result_t
//
// One item per cycle is sustained while result_ready is high; each item gives
// one result through an input register and then a result register.
// All timer state updates in the cycle the item leaves the input register.
// arst_n clears all timers, the prescaler and both valid flags.
// A stalled result holds the item in the input register; a further item is
// taken once the result register frees, so the block never loses a cycle.
`default_nettype none

module compare_overflow_timer_bank (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  cotb_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output cotb_pkg::result_t   result
);
	import cotb_pkg::*;

	item_t                item_s1;
	logic                 valid_s1;
	result_t              result_q;
	logic                 result_valid_q;
	logic [7:0]           pre_q;
	logic [7:0]           pre_next;
	logic                 move;
	logic                 is_tick;
	tick_t                tick;
	view_t                view [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] irq_vec;
	logic [IRQ_LINES-1:0] irq_out;
	logic [15:0]          rd;

	assign move       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || move;
	assign is_tick    = (item_s1.action == ACT_TICK);
	assign pre_next   = pre_q + 8'd1;

	assign tick.en     = is_tick;
	assign tick.p16    = (pre_next[3:0] == 4'd0);
	assign tick.p256   = (pre_next == 8'd0);
	assign tick.hblank = item_s1.hblank_pulse;

	for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_timer
		wr_t  wr;
		logic hit;

		assign hit           = (32'(item_s1.timer_index) == t);
		assign wr.en         = hit && (item_s1.action == ACT_WRITE);
		assign wr.reg_select = item_s1.reg_select;
		assign wr.data       = item_s1.write_data;

		cotb_timer u_timer (
			.clk    (clk),
			.arst_n (arst_n),
			.step   (move),
			.tick   (tick),
			.wr     (wr),
			.view   (view[t])
		);

		assign irq_vec[t] = view[t].irq_next;
	end

	for (genvar b = 0; b < IRQ_LINES; b++) begin : g_irq
		if (b < NUM_TIMERS) begin : g_on
			assign irq_out[b] = irq_vec[b];
		end else begin : g_off
			assign irq_out[b] = 1'b0;
		end
	end

	always_comb begin
		rd = 16'd0;
		if (item_s1.action == ACT_READ) begin
			for (int t = 0; t < NUM_TIMERS; t++) begin
				if (32'(item_s1.timer_index) == t) begin
					unique case (item_s1.reg_select)
						REG_COUNT:   rd = 16'(view[t].count);
						REG_MODE:    rd = view[t].mode;
						REG_COMPARE: rd = 16'(view[t].compare);
						default:     rd = 16'd0;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			pre_q          <= 8'd0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (move && is_tick) begin
				pre_q <= pre_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (move) begin
			result_q.read_data <= rd;
			result_q.irq_lines <= irq_out;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== design/cotb_checker.sv =====
`default_nettype none

module cotb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input cotb_pkg::item_t     item,
	input logic                result_valid,
	input logic                result_ready,
	input cotb_pkg::result_t   result
);
	import cotb_pkg::*;

	// A stalled result keeps its value until the transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// With the output side free, the block always takes an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_ready |-> item_ready)
		else $error("item_ready low while result side is free");

	// A result out of an empty block follows its item through the input and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result without a matching item transfer");

	// Nothing is offered in the first cycle after reset.
	assert property (@(posedge clk)
		!$past(arst_n) |-> !result_valid)
		else $error("result valid straight after reset");

	logic unused_item;
	assign unused_item = ^item;

endmodule

bind compare_overflow_timer_bank cotb_checker u_cotb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
